// File: src/fidct_pkg.sv
`default_nettype none
package fidct_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_WIDTH = 6;
  localparam int LINE_LEN   = 8;

  typedef struct packed {
    logic signed [15:0] coefficient;
    logic               mode;
    logic               in_last;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               out_last;
  } out_word_t;

  // datapath commands from the controller
  typedef struct packed {
    logic       load;       // write incoming coefficient
    logic       rd_en;      // read store at rd_addr
    logic [5:0] rd_addr;
    logic [2:0] rd_elem;    // element position of the word being read
    logic       calc;       // line gathered, start butterfly
    logic       wb_en;      // write back one result element
    logic [5:0] wb_addr;
    logic [2:0] wb_elem;
    logic       row_pass;   // row pass uses shift of 5
    logic       dc_fill;    // write dc value at wb_addr
    logic       dc_grab;    // compute dc value from read data
    logic       emit;       // present read word as a sample
    logic       emit_last;
  } dp_cmd_t;

  // 32-bit constant multiply with arithmetic shift right by 8
  function automatic logic [31:0] mulk(input logic [31:0] x, input logic [9:0] k);
    logic [31:0] p;
    p = x * {22'd0, k};
    return 32'($signed(p) >>> 8);
  endfunction

endpackage
`default_nettype wire

// File: src/fidct_datapath.sv
`default_nettype none
module fidct_datapath
  import fidct_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire dp_cmd_t   cmd,
  input  wire logic [5:0] load_addr,
  input  wire in_word_t  in_word,
  output logic           calc_done,
  output logic           result_valid,
  output out_word_t      result
);

  logic [31:0] store [64];
  logic [31:0] rd_data;
  logic        rd_vld;
  logic [2:0]  rd_elem_q;
  logic        emit_q, emit_last_q, dc_grab_q;
  logic [31:0] d [LINE_LEN];
  logic [31:0] r [LINE_LEN];
  logic [31:0] dc_val;

  // butterfly stage registers
  logic [31:0] s_e10, s_e11, s_e13, s_m362a, s_o10, s_o11, s_o12, s_o13;
  logic        s_zero;
  logic [31:0] s_d0;
  logic [31:0] f5, m669, m362b, m277, t7, t0, t1, t2, t3;
  logic [31:0] u_t0, u_t1, u_t2, u_t3, u_t7, u_f5, u_m669, u_m362b, u_m277;
  logic        u_zero;
  logic [31:0] u_d0;
  logic [1:0]  phase;
  logic        busy_calc;
  logic [31:0] t4, t5, t6, zv;
  logic [4:0]  sh;

  // store write port and registered read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      store[load_addr] <= 32'($signed(in_word.coefficient[COEF_WIDTH-1:0]));
    end else if (cmd.dc_fill) begin
      store[cmd.wb_addr] <= dc_val;
    end else if (cmd.wb_en) begin
      store[cmd.wb_addr] <= r[cmd.wb_elem];
    end
    if (cmd.rd_en) begin
      rd_data <= store[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      emit_q <= 1'b0;
      dc_grab_q <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
      emit_q <= cmd.emit;
      dc_grab_q <= cmd.dc_grab;
    end
    rd_elem_q <= cmd.rd_elem;
    emit_last_q <= cmd.emit_last;
  end

  // line gather and dc capture
  always_ff @(posedge clk) begin
    if (rd_vld && !emit_q && !dc_grab_q) begin
      d[rd_elem_q] <= rd_data;
    end
    if (dc_grab_q) begin
      dc_val <= 32'($signed(rd_data) >>> 5);
    end
  end

  assign sh = cmd.row_pass ? 5'd5 : 5'd0;

  // stage one: even and odd sums
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      s_e10 <= d[0] + d[4];
      s_e11 <= d[0] - d[4];
      s_e13 <= d[2] + d[6];
      s_m362a <= mulk(d[2] - d[6], 10'd362);
      s_o13 <= d[3] + d[5];
      s_o10 <= d[3] - d[5];
      s_o11 <= d[1] + d[7];
      s_o12 <= d[1] - d[7];
      s_zero <= ((d[1] | d[2] | d[3] | d[4] | d[5] | d[6] | d[7]) == 32'd0);
      s_d0 <= d[0];
    end
  end

  // stage two: products
  always_comb begin
    f5 = mulk(s_o12 - s_o10, 10'd473);
    m669 = mulk(s_o10, 10'd669);
    m362b = mulk(s_o11 - s_o13, 10'd362);
    m277 = mulk(s_o12, 10'd277);
    t7 = s_o11 + s_o13;
    t0 = s_e10 + s_e13;
    t3 = s_e10 - s_e13;
    t1 = s_e11 + (s_m362a - s_e13);
    t2 = s_e11 - (s_m362a - s_e13);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
      busy_calc <= 1'b0;
    end else begin
      if (cmd.calc) begin
        busy_calc <= 1'b1;
        phase <= 2'd0;
      end else if (busy_calc) begin
        phase <= phase + 2'd1;
        if (phase == 2'd1) busy_calc <= 1'b0;
      end
    end
    if (busy_calc && phase == 2'd0) begin
      u_t0 <= t0; u_t1 <= t1; u_t2 <= t2; u_t3 <= t3; u_t7 <= t7;
      u_f5 <= f5; u_m669 <= m669; u_m362b <= m362b; u_m277 <= m277;
      u_zero <= s_zero; u_d0 <= s_d0;
    end
  end

  // stage three: odd chain and outputs, held for write-back
  always_comb begin
    t6 = u_m669 + u_f5 - u_t7;
    t5 = u_m362b - t6;
    t4 = u_m277 - u_f5 + t5;
    zv = 32'($signed(u_d0) >>> sh);
  end

  always_ff @(posedge clk) begin
    if (busy_calc && phase == 2'd1) begin
      if (u_zero) begin
        for (int i = 0; i < LINE_LEN; i++) r[i] <= zv;
      end else begin
        r[0] <= 32'($signed(u_t0 + u_t7) >>> sh);
        r[7] <= 32'($signed(u_t0 - u_t7) >>> sh);
        r[1] <= 32'($signed(u_t1 + t6) >>> sh);
        r[6] <= 32'($signed(u_t1 - t6) >>> sh);
        r[2] <= 32'($signed(u_t2 + t5) >>> sh);
        r[5] <= 32'($signed(u_t2 - t5) >>> sh);
        r[4] <= 32'($signed(u_t3 + t4) >>> sh);
        r[3] <= 32'($signed(u_t3 - t4) >>> sh);
      end
    end
  end

  assign calc_done = busy_calc && phase == 2'd1;

  // sample output
  assign result_valid = emit_q;
  assign result.sample = rd_data;
  assign result.out_last = emit_last_q;

endmodule
`default_nettype wire

// File: src/fidct_ctrl.sv
`default_nettype none
module fidct_ctrl
  import fidct_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire in_word_t   in_word,
  input  wire logic       calc_done,
  output logic            busy,
  output logic [5:0]      load_addr,
  output dp_cmd_t         cmd
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_DCRD = 3'd4;
  localparam logic [2:0] S_DCWR = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state, state_next;
  logic [5:0] load_index;
  logic       row_pass;
  logic [2:0] line;
  logic [3:0] elem;     // read counter: reads at 0 to 7, then 8 and 9 drain the registered read and gather
  logic [2:0] wb_cnt;
  logic [6:0] emit_cnt;
  logic       accept;

  assign accept = start && !busy;
  assign busy = (state != S_LOAD);
  assign load_addr = load_index;

  // address of element e of the current line
  function automatic logic [5:0] addr_of(input logic rp, input logic [2:0] ln,
                                         input logic [2:0] e);
    return rp ? {ln, e} : {e, ln};
  endfunction

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.row_pass = row_pass;
    cmd.load = accept;
    unique case (state)
      S_LOAD: begin
        if (accept && in_word.in_last) state_next = in_word.mode ? S_DCRD : S_READ;
      end
      S_READ: begin
        if (elem < 4'd8) begin
          cmd.rd_en = 1'b1;
          cmd.rd_addr = addr_of(row_pass, line, elem[2:0]);
          cmd.rd_elem = elem[2:0];
        end else if (elem == 4'd9) begin
          cmd.calc = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (calc_done) state_next = S_WB;
      end
      S_WB: begin
        cmd.wb_en = 1'b1;
        cmd.wb_elem = wb_cnt;
        cmd.wb_addr = addr_of(row_pass, line, wb_cnt);
        if (wb_cnt == 3'd7) begin
          state_next = (row_pass && line == 3'd7) ? S_EMIT : S_READ;
        end
      end
      S_DCRD: begin
        if (elem == 4'd0) begin
          cmd.rd_en = 1'b1;
          cmd.rd_addr = 6'd0;
          cmd.dc_grab = 1'b1;
        end else if (elem == 4'd2) begin
          state_next = S_DCWR;
        end
      end
      S_DCWR: begin
        cmd.dc_fill = 1'b1;
        cmd.wb_addr = emit_cnt[5:0];
        if (emit_cnt == 7'd63) state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = emit_cnt[5:0];
        cmd.emit = 1'b1;
        cmd.emit_last = (emit_cnt == 7'd63);
        if (emit_cnt == 7'd63) state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      load_index <= '0;
      row_pass <= 1'b0;
      line <= '0;
      elem <= '0;
      wb_cnt <= '0;
      emit_cnt <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        load_index <= in_word.in_last ? 6'd0 : load_index + 6'd1;
      end
      unique case (state)
        S_LOAD: begin
          row_pass <= 1'b0; line <= '0; elem <= '0; wb_cnt <= '0; emit_cnt <= '0;
        end
        S_READ: elem <= (elem < 4'd9) ? elem + 4'd1 : 4'd0;
        S_CALC: ;
        S_WB: begin
          wb_cnt <= wb_cnt + 3'd1;
          if (wb_cnt == 3'd7) begin
            line <= line + 3'd1;
            if (line == 3'd7) row_pass <= 1'b1;
          end
        end
        S_DCRD: elem <= elem + 4'd1;
        S_DCWR: emit_cnt <= (emit_cnt == 7'd63) ? 7'd0 : emit_cnt + 7'd1;
        S_EMIT: emit_cnt <= emit_cnt + 7'd1;
        default: ;
      endcase
    end
  end

  // no load while busy, write-back never overlaps a read, and emit returns to load after the last sample
  assert property (@(posedge clk) disable iff (rst) busy |-> !cmd.load)
    else $error("load while busy");
  assert property (@(posedge clk) disable iff (rst) !(cmd.wb_en && cmd.rd_en))
    else $error("write-back overlaps read");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && emit_cnt == 7'd63) |=> state == S_LOAD)
    else $error("emit did not end block");

endmodule
`default_nettype wire

// File: src/fast_idct_8x8_top.sv
`default_nettype none
// 8x8 inverse dct. Coefficients are taken one per cycle in row-major order
// while busy is low; the word with in_last set closes the block. In full mode
// the block then runs 16 line passes (columns, then rows), each made of 8
// store reads, a drain of the registered read and gather, the butterfly and 8
// write-backs through the single store, then emits 64 samples on consecutive
// cycles with strobe high. In dc-only mode it instead fetches the dc value,
// fills the store with it and emits the 64 samples the same way. busy stays
// high after the last coefficient until the emit ends, and the last sample
// shows in the first cycle with busy low. The receiver cannot stall: each
// sample shows for exactly one cycle.
module fast_idct_8x8_top
  import fidct_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire in_word_t  in_data,
  output logic           busy,
  output logic           strobe,
  output out_word_t      out_data
);

  dp_cmd_t    cmd;
  logic [5:0] load_addr;
  logic       calc_done;

  fidct_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .in_word(in_data),
    .calc_done(calc_done), .busy(busy), .load_addr(load_addr), .cmd(cmd)
  );

  fidct_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .load_addr(load_addr), .in_word(in_data),
    .calc_done(calc_done), .result_valid(strobe), .result(out_data)
  );

endmodule
`default_nettype wire
